@@ design/scope_frame_crc16_packer_core_macros.svh @@
// assertion helpers shared by the packer modules
`ifndef SCOPE_FRAME_CRC16_PACKER_CORE_MACROS_SVH
`define SCOPE_FRAME_CRC16_PACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define SFCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfcp assertion failed");
// consequent checked in the cycle after the antecedent
`define SFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfcp assertion failed");
`else
`define SFCP_ASSERT(lbl, clk, rst_n, prop)
`define SFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/sfcp_pkg.sv @@
`default_nettype none

package sfcp_pkg;

  // frame layout
  localparam int unsigned NumChans   = 4;
  localparam int unsigned DataLen    = 2 * NumChans;
  localparam int unsigned FrameLen   = DataLen + 2;
  localparam int unsigned IdxW       = $clog2(FrameLen);

  // request queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // crc-16/modbus
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic signed [15:0] chan_one;
    logic signed [15:0] chan_two;
    logic signed [15:0] chan_three;
    logic signed [15:0] chan_four;
  } sample_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic    valid;
    sample_t data;
  } queue_head_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_update_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/sfcp_fifo.sv @@
`default_nettype none

`include "scope_frame_crc16_packer_core_macros.svh"

module sfcp_fifo
  import sfcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire sample_t     in_data_i,
  output queue_head_t      head_o,
  input  wire logic        pop_i
);

  sample_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  // accept while a slot is free
  assign in_ready_o = (count_q != CntW'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid = (count_q != '0);
  assign head_o.data  = mem_q[rptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // sample storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  `SFCP_ASSERT(a_pop_not_empty, clk_i, rst_ni, pop_i |-> count_q != '0)
  `SFCP_ASSERT_NEXT(a_full_after_fill, clk_i, rst_ni,
                    push && !pop_i && count_q == CntW'(QueueDepth - 1), !in_ready_o)

endmodule

`default_nettype wire

@@ design/sfcp_back.sv @@
`default_nettype none

`include "scope_frame_crc16_packer_core_macros.svh"

module sfcp_back
  import sfcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire queue_head_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output frame_t           out_data_o
);

  sample_t         sample_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0]     crc_q;
  logic            out_valid_q;
  frame_t          out_q;
  logic [7:0]      cur_byte;
  logic            adv;
  logic            done;
  logic            is_last;

  // byte for the current frame position
  always_comb begin
    case (idx_q)
      IdxW'(0): cur_byte = sample_q.chan_one[7:0];
      IdxW'(1): cur_byte = sample_q.chan_one[15:8];
      IdxW'(2): cur_byte = sample_q.chan_two[7:0];
      IdxW'(3): cur_byte = sample_q.chan_two[15:8];
      IdxW'(4): cur_byte = sample_q.chan_three[7:0];
      IdxW'(5): cur_byte = sample_q.chan_three[15:8];
      IdxW'(6): cur_byte = sample_q.chan_four[7:0];
      IdxW'(7): cur_byte = sample_q.chan_four[15:8];
      IdxW'(8): cur_byte = crc_q[7:0];
      IdxW'(9): cur_byte = crc_q[15:8];
      default:  cur_byte = '0;
    endcase
  end

  // step when the output register is free or being drained
  assign is_last = (idx_q == IdxW'(FrameLen - 1));
  assign adv     = busy_q && (!out_valid_q || out_ready_i);
  assign done    = adv && is_last;
  assign pop_o   = head_i.valid && (!busy_q || done);

  // sequencer, running crc and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        crc_q  <= CrcInit;
      end else if (adv) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q < IdxW'(DataLen)) begin
          crc_q <= crc_update_byte(crc_q, cur_byte);
        end
        if (done) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q      <= 1'b1;
        out_q.frame_byte <= cur_byte;
        out_q.frame_last <= is_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample held for the whole frame
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= head_i.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SFCP_ASSERT(a_idx_in_frame, clk_i, rst_ni, busy_q |-> idx_q < IdxW'(FrameLen))
  `SFCP_ASSERT_NEXT(a_stall_holds_seq, clk_i, rst_ni,
                    busy_q && out_valid_q && !out_ready_i,
                    $stable(idx_q) && $stable(crc_q))
  `SFCP_ASSERT_NEXT(a_last_ends_frame, clk_i, rst_ni,
                    done && !pop_o, !busy_q)

endmodule

`default_nettype wire

@@ design/scope_frame_crc16_packer_core.sv @@
// scope frame packer with crc-16/modbus
// input channel: in_valid_i / in_ready_o carry one sample of four 16-bit
// channels (in_data_i). output channel: out_valid_o / out_ready_i carry
// one frame byte per request (out_data_o), ten per sample: each channel
// low byte first in channel order, then crc low and crc high; frame_last
// marks the crc high byte.
// a sample passes the queue and the sequencer's sample register before
// its first byte reaches the output register; the frame then runs one
// byte per cycle while the sink takes it. the sample rate is set by the
// single output byte lane; the crc advances one byte per emitted data byte.
// a two-entry sample queue sits between input and frame sequencer, so the
// next samples are taken while a frame is still going out.
// reset clears the queue, the sequencer and the output valid; no frame is
// in flight afterward and no stored state carries between samples.
// when the sink stalls the output byte holds, the sequencer pauses, and
// input requests are refused once the queue is full.
`default_nettype none

module scope_frame_crc16_packer_core
  import sfcp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire sample_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output frame_t       out_data_o
);

  queue_head_t head;
  logic        pop;

  // front: sample queue
  sfcp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: frame sequencer with crc
  sfcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
